// ===== sv/svalloc_pkg.sv =====
// shared types, constants and helpers of the voice allocator
package svalloc_pkg;

  localparam int Voices   = 16;
  localparam int IdxW     = $clog2(Voices);
  localparam int PaddrW   = 5;
  // 0.7874015 as a 24-bit fraction, exact after truncation for 7-bit inputs
  localparam int VelMul   = 13210405;
  localparam int VelShift = 24;

  typedef logic [IdxW-1:0] vidx_t;

  // request codes
  localparam logic [1:0] ReqNoteOn  = 2'd0;
  localparam logic [1:0] ReqNoteOff = 2'd1;
  localparam logic [1:0] ReqPanic   = 2'd2;

  // hand-over kinds
  localparam logic [1:0] XferNone   = 2'd0;
  localparam logic [1:0] XferSignal = 2'd1;
  localparam logic [1:0] XferState  = 2'd2;
  localparam logic [1:0] XferPhase  = 2'd3;

  // register indexes
  localparam logic [2:0] RegTranspose = 3'd0;
  localparam logic [2:0] RegNormVel   = 3'd1;
  localparam logic [2:0] RegKeySync   = 3'd2;
  localparam logic [2:0] RegMonoMode  = 3'd3;
  localparam logic [2:0] RegMpeEnable = 3'd4;

  typedef struct packed {
    logic [7:0] transpose;
    logic       normalize_velocity;
    logic       key_sync;
    logic       mono_mode;
    logic       mpe_enable;
    logic       mpe_load;
  } cfg_t;

  // one voice record in the state memory
  typedef struct packed {
    logic [7:0]  pitch;
    logic [3:0]  channel;
    logic [31:0] seq;
  } vrec_t;

  typedef struct packed {
    logic [3:0] voice;
    logic       start_voice;
    logic [7:0] note_pitch;
    logic [6:0] note_velocity;
    logic       stolen;
    logic       osc_sync;
    logic       lfo_trigger;
    logic [1:0] transfer_kind;
    logic [3:0] transfer_from;
    logic       release_voice;
    logic       found;
  } result_t;

  // velocity scaled by 0.7874015, truncated
  function automatic logic [6:0] norm_velocity(input logic [6:0] v);
    logic [30:0] p;
    p = 31'(v) * 31'(VelMul);
    return 7'(p >> VelShift);
  endfunction

  function automatic vidx_t next_idx(input vidx_t i);
    return (32'(i) == Voices - 1) ? '0 : vidx_t'(i + 1'b1);
  endfunction

endpackage

// ===== sv/svalloc_regs.sv =====
// configuration register file on the apb port
module svalloc_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [svalloc_pkg::PaddrW-1:0]  paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  output svalloc_pkg::cfg_t               cfg
);

  logic [2:0] reg_idx;
  logic       wr;

  assign reg_idx = paddr[svalloc_pkg::PaddrW-1:2];
  assign pready  = 1'b1;
  assign wr      = psel && penable && pwrite && pready;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else begin
      cfg.mpe_load <= wr && (reg_idx == svalloc_pkg::RegMpeEnable);
      if (wr) begin
        case (reg_idx)
          svalloc_pkg::RegTranspose: cfg.transpose          <= pwdata[7:0];
          svalloc_pkg::RegNormVel:   cfg.normalize_velocity <= pwdata[0];
          svalloc_pkg::RegKeySync:   cfg.key_sync           <= pwdata[0];
          svalloc_pkg::RegMonoMode:  cfg.mono_mode          <= pwdata[0];
          svalloc_pkg::RegMpeEnable: cfg.mpe_enable         <= pwdata[0];
          default: ;
        endcase
      end
    end
  end

  // read back
  always_comb begin
    case (reg_idx)
      svalloc_pkg::RegTranspose: prdata = {24'd0, cfg.transpose};
      svalloc_pkg::RegNormVel:   prdata = {31'd0, cfg.normalize_velocity};
      svalloc_pkg::RegKeySync:   prdata = {31'd0, cfg.key_sync};
      svalloc_pkg::RegMonoMode:  prdata = {31'd0, cfg.mono_mode};
      svalloc_pkg::RegMpeEnable: prdata = {31'd0, cfg.mpe_enable};
      default:                   prdata = 32'd0;
    endcase
  end

endmodule

// ===== sv/synth_voice_allocator.sv =====
// polyphonic voice allocator with voice stealing, top level
//
// Input stream (s_*): one event per transfer; s_tuser holds the request kind
// (note on, note off, panic), s_tdata the channel, pitch, velocity, playing
// mask and sustain flag. Output stream (m_*): one result per event, with the
// chosen or released voice, start/steal/sync flags and the live voice mask;
// m_tuser holds the hand-over kind.
// Voice records (pitch, channel, key-down sequence) sit in a 16-entry memory
// with a registered read port; key-down, live and valid bits are flip-flops.
// A note on scans all voices through the memory port and then commits the
// chosen voice, with a mono hand-over step when a voice is live; a note off
// or a note on with zero velocity scans for a held voice, and in mono mode
// scans again once a held voice matched; panic and unused kinds go straight
// to the result. The memory port gives one read per cycle.
// The block takes one event at a time; a finished result sits in the output
// register while the next event is taken. If the receiver stalls, the next
// result waits inside until the output register frees.
// Reset clears all voices, the pointer, the sequence counter and registers;
// no clearing pass is needed, valid bits stand for the reset values.
module synth_voice_allocator (
  input  logic                            clk,
  input  logic                            rst,
  // event in
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [39:0]                     s_tdata,  // channel, pitch, velocity,
                                                    // playing_mask, sustain_held
  input  logic [1:0]                      s_tuser,  // req_type
  // result out
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [47:0]                     m_tdata,  // voice, start_voice, note_pitch,
                                                    // note_velocity, stolen, osc_sync,
                                                    // lfo_trigger, transfer_from,
                                                    // release_voice, found, live_mask
  output logic [1:0]                      m_tuser,  // transfer_kind
  // configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [svalloc_pkg::PaddrW-1:0]  paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  localparam int V  = svalloc_pkg::Voices;
  localparam int IW = svalloc_pkg::IdxW;

  typedef enum logic [2:0] {
    S_IDLE, S_ON_SCAN, S_ON_WRITE, S_ON_MONO, S_OFF_SCAN, S_OFF_SCAN2, S_FINISH
  } state_t;

  svalloc_pkg::cfg_t    cfg;
  state_t               state;

  // latched event
  logic [3:0]           in_chan;
  logic [7:0]           in_pitch;
  logic [6:0]           in_velo;
  logic [15:0]          in_play;
  logic                 in_sus;

  // per-voice flags
  logic [V-1:0]         pvalid, svalid, keydown, live;
  svalloc_pkg::vidx_t   pointer;
  logic [31:0]          seq_counter;
  logic                 mpe_active;

  // scan control
  svalloc_pkg::vidx_t   rd_idx, idx_d;
  logic [IW:0]          iss_cnt;
  logic                 dv;
  logic                 scan_done;

  // note on pick
  svalloc_pkg::vidx_t   best;
  logic [2:0]           best_s;
  logic [31:0]          best_seq;
  logic                 first;
  logic                 mpe_clr;
  svalloc_pkg::vidx_t   m1, m2;
  logic                 m1v, m2v;
  logic                 lfo;
  svalloc_pkg::vidx_t   fl_q, fl_c;

  // note off search
  logic                 fv, hv;
  svalloc_pkg::vidx_t   fn, target;
  logic [7:0]           high;

  svalloc_pkg::result_t res;
  svalloc_pkg::result_t res_init;
  svalloc_pkg::result_t out_res;
  logic [15:0]          out_live;

  // memory
  svalloc_pkg::vrec_t   mem [V];
  svalloc_pkg::vrec_t   rdata, mem_wdata;
  logic                 mem_we, mem_re;
  svalloc_pkg::vidx_t   mem_raddr;

  // evaluation of the entry returned by the memory
  logic [31:0]          d_seq;
  logic                 d_pmatch;
  logic [2:0]           d_score;
  logic                 d_better;
  logic                 d_hit;

  svalloc_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  assign s_tready  = (state == S_IDLE);
  assign scan_done = !dv && (iss_cnt == (IW+1)'(V));

  // cleared result for a new event, panic flags the phase reset
  always_comb begin
    res_init          = '0;
    res_init.osc_sync = (s_tuser == svalloc_pkg::ReqPanic);
  end

  // first live voice, lowest index
  always_comb begin
    fl_c = '0;
    for (int i = V - 1; i >= 0; i--) begin
      if (live[i]) fl_c = svalloc_pkg::vidx_t'(i);
    end
  end

  // memory port control
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = rd_idx;
    if ((state == S_ON_SCAN || state == S_OFF_SCAN || state == S_OFF_SCAN2) &&
        iss_cnt != (IW+1)'(V)) begin
      mem_re = 1'b1;
    end else if (state == S_ON_WRITE) begin
      mem_re    = 1'b1;
      mem_raddr = fl_c;
    end
    mem_we    = (state == S_ON_WRITE);
    mem_wdata = '{pitch: in_pitch, channel: in_chan, seq: seq_counter};
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[best] <= mem_wdata;
    if (mem_re) rdata <= mem[mem_raddr];
  end

  // scoring of one entry
  always_comb begin
    d_seq    = svalid[idx_d] ? rdata.seq : '1;
    d_pmatch = pvalid[idx_d] && (rdata.pitch == in_pitch);
    d_score  = {!in_play[idx_d], !keydown[idx_d], d_pmatch};
    d_better = first || (d_score > best_s) ||
               ((d_score == best_s) && ($signed(d_seq) < $signed(best_seq)));
    d_hit    = mpe_active ? (rdata.channel == in_chan) : d_pmatch;
  end

  // sequencer and voice state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      pvalid      <= '0;
      svalid      <= '0;
      keydown     <= '0;
      live        <= '0;
      pointer     <= '0;
      seq_counter <= '0;
      mpe_active  <= 1'b0;
      m_tvalid    <= 1'b0;
      iss_cnt     <= '0;
      dv          <= 1'b0;
    end else begin
      if (cfg.mpe_load) mpe_active <= cfg.mpe_enable;
      if (m_tvalid && m_tready && state != S_FINISH) m_tvalid <= 1'b0;

      // shared read sweep
      if (state == S_ON_SCAN || state == S_OFF_SCAN || state == S_OFF_SCAN2) begin
        if (iss_cnt != (IW+1)'(V)) begin
          rd_idx  <= svalloc_pkg::next_idx(rd_idx);
          iss_cnt <= iss_cnt + 1'b1;
          dv      <= 1'b1;
          idx_d   <= rd_idx;
        end else begin
          dv <= 1'b0;
        end
      end

      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            res      <= res_init;
            in_chan  <= s_tdata[3:0];
            in_pitch <= {1'b0, s_tdata[10:4]} + cfg.transpose;
            in_velo  <= cfg.normalize_velocity ?
                        svalloc_pkg::norm_velocity(s_tdata[17:11]) : s_tdata[17:11];
            in_play  <= s_tdata[33:18];
            in_sus   <= s_tdata[34];
            iss_cnt  <= '0;
            dv       <= 1'b0;
            first    <= 1'b1;
            mpe_clr  <= 1'b0;
            m1v      <= 1'b0;
            m2v      <= 1'b0;
            fv       <= 1'b0;
            hv       <= 1'b0;
            lfo      <= ~|keydown;
            case (s_tuser)
              svalloc_pkg::ReqNoteOn: begin
                if (s_tdata[17:11] != 7'd0) begin
                  rd_idx <= pointer;
                  state  <= S_ON_SCAN;
                end else begin
                  rd_idx <= '0;
                  state  <= S_OFF_SCAN;
                end
              end
              svalloc_pkg::ReqNoteOff: begin
                rd_idx <= '0;
                state  <= S_OFF_SCAN;
              end
              svalloc_pkg::ReqPanic: begin
                pvalid  <= '0;
                keydown <= '0;
                live    <= '0;
                state   <= S_FINISH;
              end
              default: state <= S_FINISH;
            endcase
          end
        end

        // score every voice from the round-robin pointer
        S_ON_SCAN: begin
          if (dv) begin
            if (d_better) begin
              best     <= idx_d;
              best_s   <= d_score;
              best_seq <= d_seq;
              first    <= 1'b0;
            end
            if (keydown[idx_d] && rdata.channel == in_chan) mpe_clr <= 1'b1;
            if (in_play[idx_d] && d_pmatch) begin
              if (!m1v || idx_d < m1) begin
                m1  <= idx_d;
                m1v <= 1'b1;
                m2  <= m1;
                m2v <= m1v;
              end else if (!m2v || idx_d < m2) begin
                m2  <= idx_d;
                m2v <= 1'b1;
              end
            end
          end
          if (scan_done) state <= S_ON_WRITE;
        end

        // commit the chosen voice
        S_ON_WRITE: begin
          pvalid[best]      <= 1'b1;
          svalid[best]      <= 1'b1;
          keydown[best]     <= 1'b1;
          seq_counter       <= seq_counter + 32'd1;
          pointer           <= svalloc_pkg::next_idx(best);
          if (mpe_active && mpe_clr) mpe_active <= 1'b0;
          res.voice         <= 4'(best);
          res.start_voice   <= 1'b1;
          res.note_pitch    <= in_pitch;
          res.note_velocity <= in_velo;
          res.stolen        <= in_play[best];
          res.osc_sync      <= cfg.key_sync && !in_play[best];
          res.lfo_trigger   <= lfo;
          if (cfg.mono_mode) begin
            if (|live) begin
              fl_q  <= fl_c;
              state <= S_ON_MONO;
            end else begin
              live[best] <= 1'b1;
              state      <= S_FINISH;
            end
          end else begin
            if (!cfg.key_sync) begin
              if (m1v && m1 != best) begin
                res.transfer_kind <= svalloc_pkg::XferPhase;
                res.transfer_from <= 4'(m1);
              end else if (m1v && m2v) begin
                res.transfer_kind <= svalloc_pkg::XferPhase;
                res.transfer_from <= 4'(m2);
              end
            end
            live[best] <= 1'b1;
            state      <= S_FINISH;
          end
        end

        // mono hand-over from the first live voice
        S_ON_MONO: begin
          if (!keydown[fl_q]) begin
            live[fl_q]        <= 1'b0;
            live[best]        <= 1'b1;
            res.transfer_kind <= svalloc_pkg::XferSignal;
            res.transfer_from <= 4'(fl_q);
          end else if (fl_q != best && rdata.pitch < in_pitch) begin
            live[fl_q]        <= 1'b0;
            live[best]        <= 1'b1;
            res.transfer_kind <= svalloc_pkg::XferState;
            res.transfer_from <= 4'(fl_q);
          end
          state <= S_FINISH;
        end

        // find the first held voice of this note, or of this channel with MPE active
        S_OFF_SCAN: begin
          if (dv && !fv && d_hit && keydown[idx_d]) begin
            fv <= 1'b1;
            fn <= idx_d;
          end
          if (scan_done) begin
            if (fv) begin
              keydown[fn]       <= 1'b0;
              res.voice         <= 4'(fn);
              res.found         <= 1'b1;
              res.release_voice <= !in_sus;
              if (cfg.mono_mode) begin
                rd_idx  <= '0;
                iss_cnt <= '0;
                state   <= S_OFF_SCAN2;
              end else begin
                state <= S_FINISH;
              end
            end else begin
              state <= S_FINISH;
            end
          end
        end

        // highest remaining held key takes over in mono mode
        S_OFF_SCAN2: begin
          if (dv && keydown[idx_d] && (!hv || rdata.pitch > high)) begin
            hv     <= 1'b1;
            high   <= rdata.pitch;
            target <= idx_d;
          end
          if (scan_done) begin
            if (hv && live[fn]) begin
              live[fn]          <= 1'b0;
              live[target]      <= 1'b1;
              res.voice         <= 4'(target);
              res.transfer_kind <= svalloc_pkg::XferState;
              res.transfer_from <= 4'(fn);
            end
            state <= S_FINISH;
          end
        end

        // hand the result to the output register
        S_FINISH: begin
          if (!m_tvalid || m_tready) begin
            out_res  <= res;
            out_live <= 16'(live);
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // output packing
  assign m_tdata = {3'd0, out_live, out_res.found, out_res.release_voice,
                    out_res.transfer_from, out_res.lfo_trigger, out_res.osc_sync,
                    out_res.stolen, out_res.note_velocity, out_res.note_pitch,
                    out_res.start_voice, out_res.voice};
  assign m_tuser = out_res.transfer_kind;

endmodule

// ===== sv/svalloc_checker.sv =====
// port-level checks of the voice allocator, bound to the top level
module svalloc_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata,
  input logic [1:0]  m_tuser
);

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // a started voice never reports a note-off match or release
  a_start_excl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[4] |-> !m_tdata[28] && !m_tdata[27])
    else $error("note on reported note off fields");

  // without start or match there is no release and no hand-over
  a_idle_result: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[4] && !m_tdata[28] |-> !m_tdata[27] && m_tuser == 2'd0)
    else $error("release or hand-over without a voice");

endmodule

bind synth_voice_allocator svalloc_checker u_svalloc_checker (
  .clk, .rst, .m_tvalid, .m_tready, .m_tdata, .m_tuser
);
